// File: rtl/core/wrmean_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Windowed and running mean: shared definitions
// Field widths, the divider request and response types, and a width helper.
// ============================================================================
package wrmean_pkg;

    localparam int SAMPLE_W       = 8;
    localparam int COUNT_W        = 32;
    localparam int SUM_W          = 40;
    localparam int MEAN_W         = 8;
    localparam int STEP_W         = 6;
    localparam int WINDOW_LEN_DEF = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

    // Request to the serial divider. The dividend is left-aligned, and
    // steps gives how many of its top bits take part in the division.
    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   dividend;
        logic [COUNT_W-1:0] divisor;
        logic [STEP_W-1:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

    // Width of a sum of n full-scale samples.
    function automatic int wsum_w(input int n);
        return $clog2(n * ((1 << SAMPLE_W) - 1) + 1);
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/wrmean_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Windowed and running mean: sample window
// Shift line of the held samples, fill count and an incremental window sum.
// ============================================================================
module wrmean_window #(
    parameter int WINDOW_LEN = wrmean_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_load,
    input  wire logic [wrmean_pkg::SAMPLE_W-1:0]               i_sample,
    output logic                                               o_full,
    output logic [wrmean_pkg::SAMPLE_W-1:0]                    o_oldest,
    output logic [wrmean_pkg::wsum_w(WINDOW_LEN)-1:0]          o_wsum
);
    import wrmean_pkg::*;

    localparam int HELD_LEN = WINDOW_LEN - 1;
    localparam int FILL_W   = $clog2(WINDOW_LEN);
    localparam int WS_W     = wsum_w(WINDOW_LEN);

    logic [SAMPLE_W-1:0] r_store [HELD_LEN];
    logic [FILL_W-1:0]   r_fill;
    logic [WS_W-1:0]     r_held;
    logic [WS_W-1:0]     n_held;

    assign o_full   = (r_fill == FILL_W'(HELD_LEN));
    assign o_oldest = r_store[0];
    // Sum of the window that the offered sample would complete.
    assign o_wsum   = r_held + WS_W'(i_sample);

    // The sum of held samples loses the oldest one only once the line is full.
    assign n_held = o_wsum - (o_full ? WS_W'(r_store[0]) : WS_W'(0));

    // New samples always enter at the young end, so that the oldest one
    // reaches the head exactly when the line becomes full.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < HELD_LEN - 1; i++) begin
                r_store[i] <= r_store[i + 1];
            end
            r_store[HELD_LEN-1] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_held <= '0;
        end else if (i_load) begin
            r_held <= n_held;
            if (!o_full) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/wrmean_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Windowed and running mean: serial divider
// Restoring division that retires one quotient bit per cycle.
// ============================================================================
module wrmean_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire wrmean_pkg::t_div_req i_req,
    output wrmean_pkg::t_div_rsp      o_rsp
);
    import wrmean_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [COUNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]    r_dvd;
    logic [SUM_W-1:0]    r_quo;
    logic [COUNT_W-1:0]  r_dvs;

    logic [COUNT_W:0]    trial;
    logic [COUNT_W+1:0]  diff;
    logic                qbit;
    logic [COUNT_W-1:0]  n_rem;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign trial = {r_rem, r_dvd[SUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_dvs};
    assign qbit  = !diff[COUNT_W+1];
    assign n_rem = qbit ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[SUM_W-2:0], 1'b0};
            r_quo <= {r_quo[SUM_W-2:0], qbit};
        end
    end

    // A new division is never started on top of one in progress.
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted while busy");

    // Completion follows a busy cycle.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without work");

    // While busy there is always at least one step left.
    a_busy_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with no steps left");

endmodule
`default_nettype wire

// File: rtl/core/windowed_and_running_mean_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A sample that completes a window is answered once the serial divider has formed the
//   mean over all 40 dividend bits and then the window average one bit per cycle, the
//   average taking W steps, W being the window-sum width (11 bits for a window of five).
//   No new sample is accepted until that result has been handed to the output register.
// Filling samples are accepted one per cycle and produce no transaction.
// Reset (synchronous, active low) empties the window and clears the sum and the count.
// ============================================================================
// Windowed and running mean core
// Keeps a window of recent samples and a cumulative mean of retired samples.
// ============================================================================
module windowed_and_running_mean_core #(
    parameter int WINDOW_LEN = wrmean_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_sample_valid,
    output logic                                    o_sample_ready,
    input  wire logic [wrmean_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                                    o_result_valid,
    input  wire logic                               i_result_ready,
    output logic [wrmean_pkg::COUNT_W-1:0]          o_retired_count,
    output logic [wrmean_pkg::MEAN_W-1:0]           o_cumulative_mean,
    output logic [wrmean_pkg::MEAN_W-1:0]           o_window_average
);
    import wrmean_pkg::*;

    localparam int WS_W = wsum_w(WINDOW_LEN);

    // One-hot sequencer: idle, mean division, average division, and a hold
    // state that waits for the output register to free up.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MEAN = 4'b0010,
        S_AVG  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic                r_div_start, n_div_start;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [WS_W-1:0]     r_wsum, n_wsum;
    logic [MEAN_W-1:0]   r_mean, n_mean;
    logic [MEAN_W-1:0]   r_avg, n_avg;
    logic                r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;
    logic [MEAN_W-1:0]   r_out_mean, n_out_mean;
    logic [MEAN_W-1:0]   r_out_avg, n_out_avg;

    logic                accept;
    logic                win_full;
    logic [SAMPLE_W-1:0] win_oldest;
    logic [WS_W-1:0]     win_sum;
    logic [SUM_W:0]      sum_add;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    assign o_sample_ready = (r_state == S_IDLE);
    assign accept         = i_sample_valid && o_sample_ready;

    wrmean_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_sample (i_sample),
        .o_full   (win_full),
        .o_oldest (win_oldest),
        .o_wsum   (win_sum)
    );

    // The single divider first forms sum / count over all 40 dividend bits,
    // then the window average, with the window sum left-aligned in the
    // dividend so that only its own bits are stepped through.
    always_comb begin
        div_req.start = r_div_start;
        if (r_state == S_MEAN) begin
            div_req.dividend = r_sum;
            div_req.divisor  = r_count;
            div_req.steps    = STEP_W'(SUM_W);
        end else begin
            div_req.dividend = {r_wsum, (SUM_W - WS_W)'(0)};
            div_req.divisor  = COUNT_W'(WINDOW_LEN);
            div_req.steps    = STEP_W'(WS_W);
        end
    end

    wrmean_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Running sum plus the retiring sample, with one carry bit for saturation.
    assign sum_add = {1'b0, r_sum} + (SUM_W + 1)'(win_oldest);

    always_comb begin
        n_state     = r_state;
        n_div_start = 1'b0;
        n_count     = r_count;
        n_sum       = r_sum;
        n_wsum      = r_wsum;
        n_mean      = r_mean;
        n_avg       = r_avg;
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        n_out_mean  = r_out_mean;
        n_out_avg   = r_out_avg;

        // The result register empties when its transaction completes.
        if (r_out_valid && i_result_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                // A sample that completes the window retires the oldest one.
                // Once the count has saturated the fold is skipped entirely.
                if (accept && win_full) begin
                    n_wsum = win_sum;
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + COUNT_W'(1);
                        n_sum   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                    end
                    n_div_start = 1'b1;
                    n_state     = S_MEAN;
                end
            end
            S_MEAN: begin
                if (div_rsp.done) begin
                    // Clamp the mean to the 8-bit result range.
                    if (div_rsp.quotient[SUM_W-1:MEAN_W] != '0) begin
                        n_mean = '1;
                    end else begin
                        n_mean = div_rsp.quotient[MEAN_W-1:0];
                    end
                    n_div_start = 1'b1;
                    n_state     = S_AVG;
                end
            end
            S_AVG: begin
                if (div_rsp.done) begin
                    n_avg   = div_rsp.quotient[MEAN_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hand over as soon as the output register is free or freeing.
                if (!r_out_valid || i_result_ready) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_count;
                    n_out_mean  = r_mean;
                    n_out_avg   = r_avg;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= n_div_start;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wsum      <= n_wsum;
        r_mean      <= n_mean;
        r_avg       <= n_avg;
        r_out_count <= n_out_count;
        r_out_mean  <= n_out_mean;
        r_out_avg   <= n_out_avg;
    end

    assign o_result_valid    = r_out_valid;
    assign o_retired_count   = r_out_count;
    assign o_cumulative_mean = r_out_mean;
    assign o_window_average  = r_out_avg;

    // Divisions are only launched by the two division states.
    a_start_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == S_MEAN || r_state == S_AVG))
        else $error("divider started outside a division state");

    // The retired count never goes backwards.
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count >= $past(r_count)))
        else $error("retired count decreased");

    // Every retired sample is at most full scale, so sum <= 255 * count.
    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum <= ({r_count, 8'h00} - {8'h00, r_count}))
        else $error("running sum exceeds its bound");

    // A delivered result always covers at least one retired sample.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_retired_count != '0))
        else $error("result with zero retired count");

endmodule
`default_nettype wire
